// ----- hdl/cpu_quota_decimal_parser_defines.svh -----
// Assertion macros shared by the CPU quota parser modules.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef CPU_QUOTA_DECIMAL_PARSER_DEFINES_SVH
`define CPU_QUOTA_DECIMAL_PARSER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold as well.
`define CQDP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CQDP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cqdp_pkg.sv -----
// Shared types, character codes and scale constants for the CPU quota parser.
// Has no dependencies; used by cqdp_parser, cqdp_quota and the top level.
`default_nettype none

package cqdp_pkg;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Largest whole part that is still a legal CPU count.
  localparam logic [13:0] WHOLE_LIMIT = 14'd1024;
  // Upper bound the whole part can ever reach (1024 * 10 + 9).
  localparam logic [13:0] WHOLE_CEIL = 14'd10249;
  localparam logic [2:0]  MAX_FRAC_DIGITS = 3'd6;

  // One whole CPU is 100000 us of quota per 100 ms period.
  localparam logic [16:0] WHOLE_QUOTA_SCALE = 17'd100000;
  // floor(n / 10) = (n * TENTH_RECIP) >> TENTH_SHIFT for any 20-bit n.
  localparam logic [19:0] TENTH_RECIP = 20'd838861;
  localparam int          TENTH_SHIFT = 23;

  localparam int QUOTA_W = 27;
  localparam int FRACQ_W = 17;

  // Parser state handed over when the terminator arrives.
  typedef struct packed {
    logic [13:0] whole;
    logic [19:0] frac;
    logic [2:0]  digits;
    logic        digit_seen;
    logic        failed;
  } snap_t;

  // Multiplier that turns the fraction digits into quota microseconds.
  // With six digits the value must be divided by ten, which is done with
  // the reciprocal and a shift after the product.
  function automatic logic [19:0] frac_mult(input logic [2:0] digits);
    logic [19:0] m;
    case (digits)
      3'd0:    m = 20'd100000;
      3'd1:    m = 20'd10000;
      3'd2:    m = 20'd1000;
      3'd3:    m = 20'd100;
      3'd4:    m = 20'd10;
      3'd5:    m = 20'd1;
      3'd6:    m = TENTH_RECIP;
      default: m = 20'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cqdp_parser.sv -----
// Character parser: keeps the whole part, fraction and flags of the string.
// Depends on cqdp_pkg and the assertion macros in the defines header.
`default_nettype none
`include "cpu_quota_decimal_parser_defines.svh"

module cqdp_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire logic [7:0]     ch,
  output logic                snap_valid,
  output cqdp_pkg::snap_t     snap
);

  logic [13:0] whole_r, whole_nxt;
  logic [19:0] frac_r, frac_nxt;
  logic [2:0]  digits_r, digits_nxt;
  logic        digit_seen_r, digit_seen_nxt;
  logic        dot_seen_r, dot_seen_nxt;
  logic        failed_r, failed_nxt;

  logic        accept;
  logic        is_term;
  logic        is_dot;
  logic        is_digit;
  logic [3:0]  digit;

  assign accept   = in_valid && in_ready;
  assign is_term  = (ch == cqdp_pkg::CH_NUL);
  assign is_dot   = (ch == cqdp_pkg::CH_DOT);
  assign is_digit = (ch >= cqdp_pkg::CH_ZERO) && (ch <= cqdp_pkg::CH_NINE);
  assign digit    = 4'(ch - cqdp_pkg::CH_ZERO);

  always_comb begin
    whole_nxt      = whole_r;
    frac_nxt       = frac_r;
    digits_nxt     = digits_r;
    digit_seen_nxt = digit_seen_r;
    dot_seen_nxt   = dot_seen_r;
    failed_nxt     = failed_r;
    if (accept) begin
      if (is_term) begin
        whole_nxt      = '0;
        frac_nxt       = '0;
        digits_nxt     = '0;
        digit_seen_nxt = 1'b0;
        dot_seen_nxt   = 1'b0;
        failed_nxt     = 1'b0;
      end else if (!failed_r) begin
        if (is_dot) begin
          if (dot_seen_r) begin
            failed_nxt = 1'b1;
          end else begin
            dot_seen_nxt = 1'b1;
          end
        end else if (!is_digit) begin
          failed_nxt = 1'b1;
        end else begin
          digit_seen_nxt = 1'b1;
          if (!dot_seen_r) begin
            if (whole_r > cqdp_pkg::WHOLE_LIMIT) begin
              failed_nxt = 1'b1;
            end else begin
              // x * 10 as (x << 3) + (x << 1); never exceeds 14 bits here.
              whole_nxt = 14'({whole_r, 3'b000} + {whole_r, 1'b0} + {10'd0, digit});
            end
          end else if (digits_r < cqdp_pkg::MAX_FRAC_DIGITS) begin
            frac_nxt   = 20'({frac_r, 3'b000} + {frac_r, 1'b0} + {16'd0, digit});
            digits_nxt = digits_r + 3'd1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r      <= '0;
      frac_r       <= '0;
      digits_r     <= '0;
      digit_seen_r <= 1'b0;
      dot_seen_r   <= 1'b0;
      failed_r     <= 1'b0;
    end else begin
      whole_r      <= whole_nxt;
      frac_r       <= frac_nxt;
      digits_r     <= digits_nxt;
      digit_seen_r <= digit_seen_nxt;
      dot_seen_r   <= dot_seen_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // The terminator hands over the state as it stands before clearing.
  assign snap_valid      = in_valid && is_term;
  assign snap.whole      = whole_r;
  assign snap.frac       = frac_r;
  assign snap.digits     = digits_r;
  assign snap.digit_seen = digit_seen_r;
  assign snap.failed     = failed_r;

  `CQDP_ASSERT_NOW(a_digits_bound, 1'b1, digits_r <= cqdp_pkg::MAX_FRAC_DIGITS,
    "fraction digit count ran past six")
  `CQDP_ASSERT_NOW(a_whole_bound, 1'b1, whole_r <= cqdp_pkg::WHOLE_CEIL,
    "whole part grew past its ceiling")
  `CQDP_ASSERT_NEXT(a_term_clears, accept && is_term,
    whole_r == '0 && frac_r == '0 && digits_r == '0 && !failed_r && !dot_seen_r,
    "parser state not cleared after terminator")

endmodule

`default_nettype wire

// ----- hdl/cqdp_quota.sv -----
// Quota computation: a product stage followed by the result register.
// Depends on cqdp_pkg and the assertion macros in the defines header.
`default_nettype none
`include "cpu_quota_decimal_parser_defines.svh"

module cqdp_quota (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           snap_valid,
  input  wire cqdp_pkg::snap_t                snap,
  output logic                                snap_ready,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_ok,
  output logic [cqdp_pkg::QUOTA_W-1:0]        out_quota
);

  // Product stage.
  logic        s1_valid_r, s1_valid_nxt;
  logic [29:0] wprod_r;
  logic [39:0] fprod_r;
  logic        reject_r;
  logic        whole_zero_r;
  logic        tenth_r;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic                         ok_r;
  logic [cqdp_pkg::QUOTA_W-1:0] quota_r;

  logic                          out_adv;
  logic                          s1_load;
  logic                          out_load;
  logic                          reject_nxt;
  logic [cqdp_pkg::FRACQ_W-1:0]  fracq;
  logic [cqdp_pkg::QUOTA_W-1:0]  sum;
  logic                          ok_nxt;

  assign out_adv    = !out_valid_r || out_ready;
  assign snap_ready = !s1_valid_r || out_adv;
  assign s1_load    = snap_valid && snap_ready;
  assign out_load   = s1_valid_r && out_adv;

  // A whole part of exactly 1024 with any nonzero fraction is over the limit.
  assign reject_nxt = snap.failed || !snap.digit_seen ||
                      (snap.whole > cqdp_pkg::WHOLE_LIMIT) ||
                      ((snap.whole == cqdp_pkg::WHOLE_LIMIT) && (snap.frac != '0));

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (snap_ready) begin
      s1_valid_nxt = snap_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      wprod_r      <= 30'(snap.whole * cqdp_pkg::WHOLE_QUOTA_SCALE);
      fprod_r      <= snap.frac * cqdp_pkg::frac_mult(snap.digits);
      reject_r     <= reject_nxt;
      whole_zero_r <= (snap.whole == '0);
      tenth_r      <= (snap.digits == cqdp_pkg::MAX_FRAC_DIGITS);
    end
  end

  // Six fraction digits carry the divide-by-ten reciprocal in the product.
  assign fracq  = tenth_r ? fprod_r[cqdp_pkg::TENTH_SHIFT +: cqdp_pkg::FRACQ_W]
                          : fprod_r[cqdp_pkg::FRACQ_W-1:0];
  assign sum    = wprod_r[cqdp_pkg::QUOTA_W-1:0] + {10'd0, fracq};
  assign ok_nxt = !reject_r && !(whole_zero_r && (fracq == '0));

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok_r    <= ok_nxt;
      quota_r <= ok_nxt ? sum : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = ok_r;
  assign out_quota = quota_r;

  `CQDP_ASSERT_NOW(a_ok_nonzero, out_valid_r && ok_r, quota_r != '0,
    "accepted quota is zero")
  `CQDP_ASSERT_NOW(a_reject_zero, out_valid_r && !ok_r, quota_r == '0,
    "rejected quota is not zero")
  `CQDP_ASSERT_NEXT(a_stage_holds, s1_valid_r && !out_adv, s1_valid_r,
    "product stage dropped an entry while blocked")

endmodule

`default_nettype wire

// ----- hdl/cpu_quota_decimal_parser.sv -----
// Pipeline: a result passes the product stage, then the result register.
// Throughput: one character beat per cycle while the first pipeline register
// has room; a string of n characters plus the terminator takes n + 1 beats,
// and up to two results queue inside a stalled output before the input stalls.
// Reset: synchronous, active low rst_n; parser state and all valid flags clear.
`default_nettype none

// Top level of the CPU quota parser. Depends on cqdp_pkg, cqdp_parser and
// cqdp_quota.
//
// Characters arrive one per beat. Digits, at most one dot, and a zero byte
// terminator make a string; the parser keeps the whole part, the fraction
// digits and a sticky error flag. Once an error is seen, characters are
// ignored until the terminator. The terminator beat snapshots the parser
// state into the quota pipeline and returns the parser to its reset state
// in the same cycle, so the next string may start on the very next beat.
//
// The quota pipeline has two registers. The first holds the products of
// the whole part by 100000 and of the fraction by its digit-count scale.
// The second is the result register: the fraction term is picked (with a
// divide by ten through a reciprocal when six fraction digits were given),
// added to the whole term and checked against the zero and range limits.
// A rejected string gives ok = 0 and a quota of 0.
module cpu_quota_decimal_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [0] ok, [27:1] quota_us, [31:28] zero
);

  logic                          snap_valid;
  logic                          snap_ready;
  cqdp_pkg::snap_t               snap;
  logic                          res_ok;
  logic [cqdp_pkg::QUOTA_W-1:0]  res_quota;

  // Every character, terminator or not, waits only on room in the first
  // pipeline register, so the input keeps flowing while a result is held.
  assign in_tready = snap_ready;

  cqdp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .ch         (in_tdata),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  cqdp_quota u_quota (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_ok     (res_ok),
    .out_quota  (res_quota)
  );

  assign out_tdata = {4'b0000, res_quota, res_ok};

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CPU quota decimal parser.
// Depends on cqdp_pkg and cpu_quota_decimal_parser; it carries its own
// predictor of the parse and checks every result beat against an expectation.

module tb_top;

  // One expected result beat: the ok flag and the quota in microseconds.
  typedef struct packed {
    logic                         ok;
    logic [cqdp_pkg::QUOTA_W-1:0] quota;
  } quota_result_t;

  // Largest legal value in micro-CPUs: 1024 CPUs.
  localparam longint unsigned MAX_MICROS = 64'd1024000000;

  // Directed table. Each row is one string; the terminator is appended by
  // the loop. A typed expectation of REJECT means ok = 0 and quota = 0, a
  // positive one means ok = 1 with that quota, and PREDICT leaves the row
  // to the predictor.
  localparam int PREDICT = -1;
  localparam int REJECT  = 0;
  localparam int DIR_ROWS = 25;

  localparam int PHASE_CHARS  = 200;     // Characters per random phase.
  localparam int HOLD_CYCLES  = 300;     // Long receiver hold-off.
  localparam int DRAIN_CYCLES = 20;      // Quiet time after the last result.
  localparam int CYCLE_LIMIT  = 400000;  // Watchdog.

  string dir_text [DIR_ROWS] = '{
    "", ".", "1024", "1024.000000", "1024.000001", "1025", "0", "0.000000",
    "0.00001", "0.000001", "1..5", "1.2.3.4", "1.0000001", "10249", "102490",
    "12a4", "3/", ":1", "1.5", "0.25", ".5", "5.", "1023.999999",
    "007.123456", "0.000019"
  };
  int dir_quota [DIR_ROWS] = '{
    REJECT, REJECT, 102400000, 102400000, REJECT, REJECT, REJECT, REJECT,
    1, REJECT, REJECT, REJECT, REJECT, REJECT, REJECT,
    REJECT, REJECT, REJECT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT,
    PREDICT, PREDICT
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] ch
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [0] ok, [27:1] quota_us, [31:28] zero

  // Predictor state, mirroring the parser registers.
  logic [13:0] whole_acc = '0;
  logic [19:0] frac_acc = '0;
  logic [2:0]  frac_cnt = '0;
  logic        saw_digit = 1'b0;
  logic        saw_dot = 1'b0;
  logic        parse_bad = 1'b0;

  quota_result_t quota_backlog[$];   // Results still owed by the block.
  logic [7:0]    char_buf[$];        // Characters of the string being built.

  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_on = 1'b0;
  logic pressure_go = 1'b0;

  cpu_quota_decimal_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 2 ns clock: one nanosecond high, one low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advances the predicted parse by one character. Ordinary characters only
  // update the state and return nothing useful; the zero byte returns the
  // expected result and clears the state for the next string.
  function automatic quota_result_t advance_parse(input logic [7:0] ch);
    quota_result_t   res;
    longint unsigned micros;
    longint unsigned scale;
    res.ok = 1'b0;
    res.quota = '0;
    if (ch != cqdp_pkg::CH_NUL) begin
      // Once an error has been seen, everything up to the terminator is
      // ignored and the rest of the state is frozen.
      if (!parse_bad) begin
        if (ch == cqdp_pkg::CH_DOT) begin
          if (saw_dot) parse_bad = 1'b1;
          else saw_dot = 1'b1;
        end else if (ch < cqdp_pkg::CH_ZERO || ch > cqdp_pkg::CH_NINE) begin
          parse_bad = 1'b1;
        end else begin
          saw_digit = 1'b1;
          // The digit value is the low nibble of its ASCII code.
          if (!saw_dot) begin
            // A whole digit is refused only once the whole part is already
            // past the limit, so the whole part tops out at 10249.
            if (whole_acc > cqdp_pkg::WHOLE_LIMIT) parse_bad = 1'b1;
            else whole_acc = 14'(whole_acc * 10 + ch[3:0]);
          end else if (frac_cnt < cqdp_pkg::MAX_FRAC_DIGITS) begin
            frac_acc = 20'(frac_acc * 10 + ch[3:0]);
            frac_cnt = frac_cnt + 3'd1;
          end else begin
            parse_bad = 1'b1;
          end
        end
      end
    end else begin
      if (!parse_bad && saw_digit && whole_acc <= cqdp_pkg::WHOLE_LIMIT) begin
        // Scale the fraction up to six digits, i.e. to micro-CPUs.
        scale = 1;
        for (int i = frac_cnt; i < cqdp_pkg::MAX_FRAC_DIGITS; i++) scale = scale * 10;
        micros = whole_acc * 64'd1000000 + frac_acc * scale;
        // quota = micros * 100000 / 1000000, which is micros / 10.
        if (micros != 0 && micros <= MAX_MICROS && micros / 10 != 0) begin
          res.ok = 1'b1;
          res.quota = cqdp_pkg::QUOTA_W'(micros / 10);
        end
      end
      whole_acc = '0;
      frac_acc = '0;
      frac_cnt = '0;
      saw_digit = 1'b0;
      saw_dot = 1'b0;
      parse_bad = 1'b0;
    end
    return res;
  endfunction

  // Offers one character beat and waits until it is taken. Idle cycles are
  // inserted ahead of the beat at the current sender rate. On acceptance the
  // predictor is advanced; a terminator files its expectation, either the
  // typed one from the directed table or the predicted one.
  task automatic send_char(input logic [7:0] ch, input int typed);
    quota_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = advance_parse(ch);
    if (ch == cqdp_pkg::CH_NUL) begin
      if (typed != PREDICT) begin
        res.ok = (typed != REJECT);
        res.quota = typed[cqdp_pkg::QUOTA_W-1:0];
      end
      quota_backlog.push_back(res);
    end
  endtask

  task automatic add_digits(input int count);
    repeat (count) char_buf.push_back(cqdp_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
  endtask

  // Appends a well-formed number with random content: a whole part of a
  // random shape (absent, one digit, a value around the legal range, or a
  // run of up to six digits), then usually a dot and up to six fraction
  // digits, now and then a seventh.
  task automatic make_number_text();
    case ($urandom_range(3))
      0: ;
      1: add_digits(1);
      2: add_text($sformatf("%0d", $urandom_range(1100)));
      default: add_digits($urandom_range(1, 6));
    endcase
    if ($urandom_range(3) != 0) begin
      char_buf.push_back(cqdp_pkg::CH_DOT);
      add_digits(($urandom_range(15) == 0) ? 7 : $urandom_range(6));
    end
  endtask

  // Fills char_buf with one random string: mostly well-formed numbers, some
  // numbers with one character spoiled, and some pure noise over the whole
  // byte range (zero excluded, since that would end the string).
  task automatic make_random_text();
    int pick;
    int pos;
    char_buf.delete();
    pick = $urandom_range(99);
    if (pick < 70) begin
      make_number_text();
    end else if (pick < 85) begin
      make_number_text();
      if (char_buf.size() == 0) begin
        char_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
        pos = $urandom_range(char_buf.size() - 1);
        char_buf[pos] = ($urandom_range(1) == 0) ? cqdp_pkg::CH_DOT
                                                 : 8'($urandom_range(1, 255));
      end
    end else begin
      repeat ($urandom_range(8)) begin
        if ($urandom_range(1) == 0) char_buf.push_back(8'($urandom_range(1, 255)));
        else if ($urandom_range(3) == 0) char_buf.push_back(cqdp_pkg::CH_DOT);
        else add_digits(1);
      end
    end
  endtask

  // Sends random strings until the phase has used up its character budget.
  task automatic run_random_phase();
    int sent;
    sent = 0;
    while (sent < PHASE_CHARS) begin
      make_random_text();
      foreach (char_buf[i]) send_char(char_buf[i], PREDICT);
      send_char(cqdp_pkg::CH_NUL, PREDICT);
      sent += char_buf.size() + 1;
    end
  endtask

  // Receiver: checks each accepted result beat against the oldest
  // expectation, then picks the ready level for the next cycle. Ready is
  // forced low while the long hold-off runs.
  always @(posedge clk) begin : result_check
    quota_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quota_backlog.size() == 0) begin
        $error("result beat 0x%08h arrived with nothing expected", out_tdata);
        fail_count++;
      end else begin
        want = quota_backlog.pop_front();
        if (out_tdata[0] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[cqdp_pkg::QUOTA_W:1] !== want.quota) begin
          $error("quota_us: expected %0d, got %0d", want.quota,
                 out_tdata[cqdp_pkg::QUOTA_W:1]);
          fail_count++;
        end
      end
    end
    out_tready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long hold-off of the receiver. Once started, it keeps ready low while
  // the sender keeps offering beats, so the result stage and its queue fill
  // up and the input must stall.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Watchdog: a run that gets stuck on a handshake ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Main sequence: reset, the directed table, then three random phases with
  // different idling, and finally the drain and the verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // First phase of idling: the sender idles rarely, the receiver often.
    send_idle_pct <= 18;
    recv_idle_pct <= 50;
    @(posedge clk);

    for (int row = 0; row < DIR_ROWS; row++) begin
      for (int i = 0; i < dir_text[row].len(); i++) begin
        send_char(dir_text[row][i], PREDICT);
      end
      send_char(cqdp_pkg::CH_NUL, dir_quota[row]);
    end
    run_random_phase();

    // Second phase: the roles swap.
    send_idle_pct <= 50;
    recv_idle_pct <= 18;
    run_random_phase();

    // Third phase: nobody idles, and the long receiver hold-off runs at its
    // start so the block backs up against a full-rate sender.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    pressure_go = 1'b1;
    run_random_phase();

    in_tvalid <= 1'b0;
    while (quota_backlog.size() != 0) @(posedge clk);
    // Stay a while longer so a stray extra result beat would be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (quota_backlog.size() != 0) begin
      $error("%0d expected results never arrived", quota_backlog.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
